// File: design/brd_pkg.sv
// Shared types, constants and codes of the BMP run-length decoder.
`timescale 1ns / 1ps

package brd_pkg;

	// Image geometry and palette sizing.
	localparam int MAX_DIM       = 4096;
	localparam int DIM_W         = 13;
	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
	localparam int RGB_W         = 24;

	// Depth of the queue between the parser and the palette stage.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Configuration port sizing and register indexes.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MODE   = 2'd2;

	// Request types.
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_PAL   = 2'd1;
	localparam logic [1:0] REQ_DATA  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_END = 2'd1;
	localparam logic [1:0] ST_ERR = 2'd2;

	// Escape codes that follow a zero first byte.
	localparam logic [7:0] ESC_EOL   = 8'h00;
	localparam logic [7:0] ESC_EOB   = 8'h01;
	localparam logic [7:0] ESC_DELTA = 8'h02;
	localparam logic [3:0] NIB_MASK  = 4'hF;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_FIRST  = 3'd0,
		PH_SECOND = 3'd1,
		PH_DX     = 3'd2,
		PH_DY     = 3'd3,
		PH_LIT    = 3'd4,
		PH_PAD    = 3'd5
	} phase_t;

	// Input item.
	typedef struct packed {
		logic [1:0]       req_type;
		logic [7:0]       data_byte;
		logic [7:0]       pal_index;
		logic [RGB_W-1:0] pal_rgb;
	} req_t;

	// Result item.
	typedef struct packed {
		logic [DIM_W-1:0] x_start;
		logic [DIM_W-1:0] row;
		logic [7:0]       count;
		logic [RGB_W-1:0] rgb_even;
		logic [RGB_W-1:0] rgb_odd;
		logic [1:0]       status;
	} rsp_t;

	// Configuration seen by the parser.
	typedef struct packed {
		logic [DIM_W-1:0] img_width;
		logic [DIM_W-1:0] img_height;
		logic             rle4_mode;
	} cfg_t;

	// Operation passed from the parser to the palette stage.
	typedef struct packed {
		logic              is_write;
		logic [DIM_W-1:0]  x;
		logic [DIM_W-1:0]  y;
		logic [7:0]        count;
		logic [1:0]        status;
		logic [PAL_AW-1:0] idx_e;
		logic [PAL_AW-1:0] idx_o;
		logic              zero_e;
		logic              zero_o;
		logic [RGB_W-1:0]  wr_rgb;
	} op_t;

endpackage

// File: design/brd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module brd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/brd_fifo.sv
// Short queue of operations between the parser and the palette stage.
`timescale 1ns / 1ps

module brd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  brd_pkg::op_t  push_op,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output brd_pkg::op_t  head
);

	brd_pkg::op_t                  mem_q [brd_pkg::FIFO_DEPTH];
	logic [brd_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [brd_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [brd_pkg::FIFO_AW:0]     cnt_q;

	assign full       = (cnt_q == (brd_pkg::FIFO_AW+1)'(brd_pkg::FIFO_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: design/brd_front.sv
// Stream parser: accepts items, tracks the cursor and queues run operations.
`timescale 1ns / 1ps

module brd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  brd_pkg::cfg_t cfg,
	input  logic          accept,
	input  brd_pkg::req_t req,
	output logic          push,
	output brd_pkg::op_t  push_op
);

	localparam int DW = brd_pkg::DIM_W;

	brd_pkg::phase_t  phase_q, phase_d;
	logic [DW-1:0]    cur_x_q, cur_x_d;
	logic [DW-1:0]    cur_y_q, cur_y_d;
	logic [7:0]       held_q, held_d;
	logic [7:0]       lit_q, lit_d;
	logic             pad_q, pad_d;
	logic             halted_q, halted_d;

	logic [DW-1:0]    w_eff;
	logic [DW-1:0]    h_eff;
	logic [7:0]       b;
	logic             rle4;

	// Run request decoded from the phase and byte.
	logic [7:0]                 run_n;
	logic [brd_pkg::PAL_AW-1:0] run_ie;
	logic [brd_pkg::PAL_AW-1:0] run_io;
	logic                       run_zo;
	logic [7:0]                 lit_n;

	// Run outcome at the current cursor.
	logic             row_bad;
	logic [DW-1:0]    avail;
	logic             clip;
	logic [DW-1:0]    run_cx;
	brd_pkg::op_t     run_op;

	logic [DW:0]      nx;
	logic [DW:0]      ny;
	logic [8:0]       b_inc;

	// Dimensions above the maximum count as the maximum.
	assign w_eff = (cfg.img_width > DW'(brd_pkg::MAX_DIM)) ? DW'(brd_pkg::MAX_DIM)
		: cfg.img_width;
	assign h_eff = (cfg.img_height > DW'(brd_pkg::MAX_DIM)) ? DW'(brd_pkg::MAX_DIM)
		: cfg.img_height;
	assign b     = req.data_byte;
	assign rle4  = cfg.rle4_mode;
	assign lit_n = (lit_q >= 8'd2) ? 8'd2 : lit_q;
	assign b_inc = {1'b0, b} + 9'd1;
	assign nx    = {1'b0, cur_x_q} + {{(DW-7){1'b0}}, held_q};
	assign ny    = {1'b0, cur_y_q} + {{(DW-7){1'b0}}, b};

	// Pixel count and palette indexes of the run that this byte would write.
	always_comb begin
		run_n  = held_q;
		run_ie = rle4 ? brd_pkg::PAL_AW'(b[7:4]) : b;
		run_io = rle4 ? brd_pkg::PAL_AW'(b & {4'h0, brd_pkg::NIB_MASK}) : b;
		run_zo = 1'b0;
		if (phase_q == brd_pkg::PH_LIT) begin
			if (rle4) begin
				run_n  = lit_n;
				run_zo = (lit_n != 8'd2);
			end else begin
				run_n = 8'd1;
			end
		end
	end

	// Clip the run at the image width and build its operation.
	assign row_bad = (cur_y_q >= h_eff);
	assign avail   = (cur_x_q >= w_eff) ? '0 : (w_eff - cur_x_q);
	assign clip    = ({{(DW-8){1'b0}}, run_n} > avail);
	assign run_cx  = clip ? (cur_x_q + avail) : (cur_x_q + {{(DW-8){1'b0}}, run_n});

	always_comb begin
		run_op        = '0;
		run_op.x      = cur_x_q;
		run_op.y      = cur_y_q;
		run_op.idx_e  = run_ie;
		run_op.idx_o  = run_io;
		run_op.zero_o = run_zo;
		if (row_bad) begin
			run_op.status = brd_pkg::ST_ERR;
			run_op.zero_e = 1'b1;
			run_op.zero_o = 1'b1;
		end else if (clip) begin
			run_op.status = brd_pkg::ST_ERR;
			run_op.count  = avail[7:0];
		end else begin
			run_op.status = brd_pkg::ST_RUN;
			run_op.count  = run_n;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= brd_pkg::PH_FIRST;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			held_q   <= '0;
			lit_q    <= '0;
			pad_q    <= 1'b0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			cur_x_q  <= cur_x_d;
			cur_y_q  <= cur_y_d;
			held_q   <= held_d;
			lit_q    <= lit_d;
			pad_q    <= pad_d;
			halted_q <= halted_d;
		end
	end

	// Next state and queued operation for each accepted item.
	always_comb begin
		brd_pkg::op_t mark;
		mark        = '0;
		mark.x      = cur_x_q;
		mark.y      = cur_y_q;
		mark.zero_e = 1'b1;
		mark.zero_o = 1'b1;
		mark.status = brd_pkg::ST_ERR;

		phase_d  = phase_q;
		cur_x_d  = cur_x_q;
		cur_y_d  = cur_y_q;
		held_d   = held_q;
		lit_d    = lit_q;
		pad_d    = pad_q;
		halted_d = halted_q;
		push     = 1'b0;
		push_op  = run_op;

		if (accept) begin
			if (req.req_type == brd_pkg::REQ_START) begin
				phase_d  = brd_pkg::PH_FIRST;
				cur_x_d  = '0;
				cur_y_d  = '0;
				held_d   = '0;
				lit_d    = '0;
				pad_d    = 1'b0;
				halted_d = 1'b0;
			end else if (req.req_type == brd_pkg::REQ_PAL) begin
				push            = 1'b1;
				push_op         = '0;
				push_op.is_write = 1'b1;
				push_op.idx_e   = req.pal_index;
				push_op.wr_rgb  = req.pal_rgb;
			end else if (req.req_type == brd_pkg::REQ_DATA && !halted_q) begin
				unique case (phase_q)
					brd_pkg::PH_FIRST: begin
						held_d  = b;
						phase_d = brd_pkg::PH_SECOND;
					end
					brd_pkg::PH_SECOND: begin
						phase_d = brd_pkg::PH_FIRST;
						if (held_q != 8'd0) begin
							push    = 1'b1;
							cur_x_d = row_bad ? cur_x_q : run_cx;
						end else if (b == brd_pkg::ESC_EOL) begin
							cur_x_d = '0;
							if (row_bad) begin
								push    = 1'b1;
								push_op = mark;
							end else begin
								cur_y_d = cur_y_q + 1'b1;
							end
						end else if (b == brd_pkg::ESC_EOB) begin
							push        = 1'b1;
							push_op     = mark;
							push_op.status = brd_pkg::ST_END;
						end else if (b == brd_pkg::ESC_DELTA) begin
							phase_d = brd_pkg::PH_DX;
						end else begin
							lit_d   = b;
							pad_d   = rle4 ? b_inc[1] : b[0];
							phase_d = brd_pkg::PH_LIT;
						end
					end
					brd_pkg::PH_DX: begin
						held_d  = b;
						phase_d = brd_pkg::PH_DY;
					end
					brd_pkg::PH_DY: begin
						phase_d = brd_pkg::PH_FIRST;
						if (nx >= {1'b0, w_eff} || ny >= {1'b0, h_eff}) begin
							push    = 1'b1;
							push_op = mark;
						end else begin
							cur_x_d = nx[DW-1:0];
							cur_y_d = ny[DW-1:0];
						end
					end
					brd_pkg::PH_LIT: begin
						lit_d   = lit_q - run_n;
						push    = 1'b1;
						cur_x_d = row_bad ? cur_x_q : run_cx;
						if (lit_q == run_n) begin
							phase_d = pad_q ? brd_pkg::PH_PAD : brd_pkg::PH_FIRST;
						end
					end
					brd_pkg::PH_PAD: begin
						pad_d   = 1'b0;
						phase_d = brd_pkg::PH_FIRST;
					end
					default: begin
						phase_d = brd_pkg::PH_FIRST;
					end
				endcase
				// Any end or error result stops the parser until a start item.
				if (push && push_op.status != brd_pkg::ST_RUN) begin
					halted_d = 1'b1;
				end
			end
		end
	end

endmodule

// File: design/brd_back.sv
// Palette stage: applies palette writes, looks up run colors, holds the result.
`timescale 1ns / 1ps

module brd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  brd_pkg::op_t  head,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output brd_pkg::rsp_t rsp
);

	logic                        s1_valid_q;
	brd_pkg::op_t                s1_op_s1;
	logic                        s1_adv;
	logic                        out_load;
	logic                        ram_we;
	logic                        ram_re;
	logic [brd_pkg::RGB_W-1:0]   rgb_e;
	logic [brd_pkg::RGB_W-1:0]   rgb_o;
	logic                        out_valid_q;
	brd_pkg::rsp_t               out_q;

	// Stage control: the lookup stage moves on when the result register frees.
	assign out_load = s1_valid_q && (!out_valid_q || rsp_ready);
	assign s1_adv   = !s1_valid_q || out_load;
	assign pop      = head_valid && (head.is_write || s1_adv);
	assign ram_we   = pop && head.is_write;
	assign ram_re   = pop && !head.is_write;

	// Two palette copies give the even and odd colors in the same cycle.
	brd_ram #(
		.WIDTH(brd_pkg::RGB_W),
		.DEPTH(brd_pkg::PALETTE_DEPTH)
	) u_pal_even (
		.clk  (clk),
		.we   (ram_we),
		.waddr(head.idx_e),
		.wdata(head.wr_rgb),
		.re   (ram_re),
		.raddr(head.idx_e),
		.rdata(rgb_e)
	);

	brd_ram #(
		.WIDTH(brd_pkg::RGB_W),
		.DEPTH(brd_pkg::PALETTE_DEPTH)
	) u_pal_odd (
		.clk  (clk),
		.we   (ram_we),
		.waddr(head.idx_e),
		.wdata(head.wr_rgb),
		.re   (ram_re),
		.raddr(head.idx_o),
		.rdata(rgb_o)
	);

	// Lookup stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_adv) begin
			s1_valid_q <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			s1_op_s1 <= head;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.x_start  <= s1_op_s1.x;
			out_q.row      <= s1_op_s1.y;
			out_q.count    <= s1_op_s1.count;
			out_q.rgb_even <= s1_op_s1.zero_e ? '0 : rgb_e;
			out_q.rgb_odd  <= s1_op_s1.zero_o ? '0 : rgb_o;
			out_q.status   <= s1_op_s1.status;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// A waiting result is kept until the transaction completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp_ready |=> out_valid_q && $stable(out_q))
		else $error("result changed while stalled");

	// A stalled lookup keeps its operation.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_op_s1))
		else $error("lookup stage lost its operation");

	// A palette read is issued only when the lookup stage can take it.
	a_re_adv: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> s1_adv && !ram_we)
		else $error("palette read issued into a busy stage");

	// Nothing is taken from an empty queue.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

// File: design/bmp_rle_run_decoder.sv
// Each accepted run passes through the queue, the lookup stage and the result register.
// Throughput: one item per cycle while the queue is not full; the queue and the result register decouple the ports.
// Palette colors are read from two RAM copies with registered reads, one per pixel parity.
// Reset clears the parser, cursor, queue and registers (width 1, height 1, RLE8 mode).
// The palette is not cleared by reset; its entries are undefined until written.
`timescale 1ns / 1ps

module bmp_rle_run_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  brd_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output brd_pkg::rsp_t                 rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [brd_pkg::PADDR_W-1:0]   paddr,
	input  logic [brd_pkg::PDATA_W-1:0]   pwdata,
	output logic [brd_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int DW = brd_pkg::DIM_W;

	brd_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;
	logic          accept;
	logic          push;
	brd_pkg::op_t  push_op;
	logic          full;
	logic          pop;
	logic          head_valid;
	brd_pkg::op_t  head;

	// Configuration registers.
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.img_width  <= DW'(1);
			cfg_q.img_height <= DW'(1);
			cfg_q.rle4_mode  <= 1'b0;
		end else if (wr_en) begin
			if (reg_idx == brd_pkg::REG_WIDTH) begin
				cfg_q.img_width <= pwdata[DW-1:0];
			end else if (reg_idx == brd_pkg::REG_HEIGHT) begin
				cfg_q.img_height <= pwdata[DW-1:0];
			end else if (reg_idx == brd_pkg::REG_MODE) begin
				cfg_q.rle4_mode <= pwdata[0];
			end
		end
	end

	// Register read-back.
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			brd_pkg::REG_WIDTH:  prdata = {{(brd_pkg::PDATA_W-DW){1'b0}}, cfg_q.img_width};
			brd_pkg::REG_HEIGHT: prdata = {{(brd_pkg::PDATA_W-DW){1'b0}}, cfg_q.img_height};
			brd_pkg::REG_MODE:   prdata = {{(brd_pkg::PDATA_W-1){1'b0}}, cfg_q.rle4_mode};
			default:             prdata = '0;
		endcase
	end

	// Input transactions are taken while the queue has room.
	assign req_ready = !full;
	assign accept    = req_valid && req_ready;

	brd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.accept (accept),
		.req    (req),
		.push   (push),
		.push_op(push_op)
	);

	brd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	brd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// File: tb/sv/tb_bmp_rle_run_decoder.sv
// Self-checking testbench for the BMP RLE8/RLE4 run decoder with a built-in decode predictor.
`timescale 1ns / 1ps

module tb_bmp_rle_run_decoder;
	import brd_pkg::*;

	localparam int ITEM_GOAL = 550;
	localparam int PHASE_ITEMS = 60;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [7:0] ESC_LEAD = 8'h00;

	// Stored transaction with the result it is predicted to cause.
	typedef struct {
		req_t r;
		bit   has_res;
		rsp_t res;
	} item_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	// Decoder state as the predictor tracks it.
	logic [RGB_W-1:0] pal_mem [PALETTE_DEPTH];
	bit pal_known [PALETTE_DEPTH];
	int cur_x = 0;
	int cur_y = 0;
	phase_t ph = PH_FIRST;
	logic [7:0] held = '0;
	int lit_left = 0;
	bit pad_due = 1'b0;
	bit stopped = 1'b0;
	logic [DIM_W-1:0] cfg_w = 13'd1;
	logic [DIM_W-1:0] cfg_h = 13'd1;
	bit cfg_rle4 = 1'b0;

	// Pending transactions, expected results and bookkeeping.
	item_rec_t items_waiting[$];
	item_rec_t in_flight;
	rsp_t runs_due[$];
	rsp_t want_rsp;
	int items_taken = 0;
	int runs_seen = 0;
	int n_items = 0;
	int n_ignored = 0;
	int n_settings = 0;
	int errors = 0;
	int cycles = 0;

	bmp_rle_run_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Clock with a 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Dimensions above the maximum behave as the maximum.
	function automatic int dim_of(logic [DIM_W-1:0] v);
		return (v > MAX_DIM) ? MAX_DIM : int'(v);
	endfunction

	// Fill in one result; anything other than a pixel run halts the decoder.
	function automatic bit post_run(int x, int y, int n, logic [RGB_W-1:0] ce,
			logic [RGB_W-1:0] co, logic [1:0] st, output rsp_t res);
		res.x_start = DIM_W'(x);
		res.row = DIM_W'(y);
		res.count = 8'(n);
		res.rgb_even = ce;
		res.rgb_odd = co;
		res.status = st;
		if (st != ST_RUN)
			stopped = 1'b1;
		return 1'b1;
	endfunction

	// Place a run at the cursor, clipping at the right edge.
	function automatic bit paint_run(int n, logic [RGB_W-1:0] ce, logic [RGB_W-1:0] co,
			output rsp_t res);
		int w, h, x, avail;
		w = dim_of(cfg_w);
		h = dim_of(cfg_h);
		x = cur_x;
		if (cur_y >= h)
			return post_run(x, cur_y, 0, '0, '0, ST_ERR, res);
		avail = (x >= w) ? 0 : w - x;
		if (n > avail) begin
			cur_x = x + avail;
			return post_run(x, cur_y, avail, ce, co, ST_ERR, res);
		end
		cur_x = x + n;
		return post_run(x, cur_y, n, ce, co, ST_RUN, res);
	endfunction

	// Advance the decoder by one transaction and return whether it yields a result.
	function automatic bit rle_decode_item(input req_t r, output rsp_t res);
		int w, h, x, y, n;
		logic [7:0] b;
		logic [RGB_W-1:0] ce, co;
		res = '0;
		b = r.data_byte;
		w = dim_of(cfg_w);
		h = dim_of(cfg_h);
		x = cur_x;
		y = cur_y;
		if (r.req_type == REQ_START) begin
			cur_x = 0;
			cur_y = 0;
			ph = PH_FIRST;
			held = '0;
			lit_left = 0;
			pad_due = 1'b0;
			stopped = 1'b0;
			return 1'b0;
		end
		if (r.req_type == REQ_PAL) begin
			pal_mem[r.pal_index] = r.pal_rgb;
			pal_known[r.pal_index] = 1'b1;
			return 1'b0;
		end
		if (r.req_type != REQ_DATA || stopped)
			return 1'b0;
		case (ph)
			PH_FIRST: begin
				held = b;
				ph = PH_SECOND;
				return 1'b0;
			end
			PH_SECOND: begin
				ph = PH_FIRST;
				// A nonzero count byte makes an encoded run.
				if (held != 8'd0) begin
					if (cfg_rle4) begin
						ce = pal_mem[b[7:4]];
						co = pal_mem[b[3:0]];
					end else begin
						ce = pal_mem[b];
						co = ce;
					end
					return paint_run(held, ce, co, res);
				end
				if (b == ESC_EOL) begin
					cur_x = 0;
					if (y >= h)
						return post_run(x, y, 0, '0, '0, ST_ERR, res);
					cur_y = y + 1;
					return 1'b0;
				end
				if (b == ESC_EOB)
					return post_run(x, y, 0, '0, '0, ST_END, res);
				if (b == ESC_DELTA) begin
					ph = PH_DX;
					return 1'b0;
				end
				// Absolute mode: the byte holds the pixel count.
				lit_left = b;
				pad_due = cfg_rle4 ? ((((int'(b) + 1) >> 1) & 1) != 0) : b[0];
				ph = PH_LIT;
				return 1'b0;
			end
			PH_DX: begin
				held = b;
				ph = PH_DY;
				return 1'b0;
			end
			PH_DY: begin
				ph = PH_FIRST;
				if (x + held >= w || y + b >= h)
					return post_run(x, y, 0, '0, '0, ST_ERR, res);
				cur_x = x + held;
				cur_y = y + b;
				return 1'b0;
			end
			PH_LIT: begin
				if (cfg_rle4) begin
					n = (lit_left >= 2) ? 2 : lit_left;
					ce = pal_mem[b[7:4]];
					co = (n == 2) ? pal_mem[b[3:0]] : '0;
				end else begin
					n = 1;
					ce = pal_mem[b];
					co = ce;
				end
				lit_left -= n;
				if (lit_left == 0)
					ph = pad_due ? PH_PAD : PH_FIRST;
				return paint_run(n, ce, co, res);
			end
			PH_PAD: begin
				pad_due = 1'b0;
				ph = PH_FIRST;
				return 1'b0;
			end
			default: begin
				ph = PH_FIRST;
				return 1'b0;
			end
		endcase
		return 1'b0;
	endfunction

	// Palette entries that the next data byte would look up.
	function automatic int palette_reads(logic [7:0] b, output int ia, output int ib);
		ia = 0;
		ib = 0;
		if (stopped)
			return 0;
		if ((ph == PH_SECOND && held != 8'd0) || ph == PH_LIT) begin
			if (!cfg_rle4) begin
				ia = b;
				return 1;
			end
			ia = b[7:4];
			ib = b[3:0];
			return (ph == PH_LIT && lit_left < 2) ? 1 : 2;
		end
		return 0;
	endfunction

	function automatic req_t rand_req();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return bits[$bits(req_t)-1:0];
	endfunction

	// Predict a transaction and queue it for the driver.
	function automatic void queue_req(req_t r);
		item_rec_t it;
		if (r.req_type == REQ_UNUSED || (r.req_type == REQ_DATA && stopped))
			n_ignored++;
		else
			n_items++;
		it.r = r;
		it.has_res = rle_decode_item(r, it.res);
		items_waiting.push_back(it);
	endfunction

	function automatic void send_pal(logic [7:0] idx, logic [RGB_W-1:0] rgb);
		req_t r;
		r = rand_req();
		r.req_type = REQ_PAL;
		r.pal_index = idx;
		r.pal_rgb = rgb;
		queue_req(r);
	endfunction

	function automatic void send_start();
		req_t r;
		r = rand_req();
		r.req_type = REQ_START;
		queue_req(r);
	endfunction

	function automatic void send_unused();
		req_t r;
		r = rand_req();
		r.req_type = REQ_UNUSED;
		queue_req(r);
	endfunction

	// Data byte; any palette entry it reads is loaded first if it was never written.
	function automatic void send_data(logic [7:0] b);
		int ia, ib, k;
		req_t r;
		k = palette_reads(b, ia, ib);
		if (k > 0 && !pal_known[ia])
			send_pal(ia[7:0], RGB_W'($urandom));
		if (k > 1 && !pal_known[ib])
			send_pal(ib[7:0], RGB_W'($urandom));
		r = rand_req();
		r.req_type = REQ_DATA;
		r.data_byte = b;
		queue_req(r);
	endfunction

	// One stream command, mostly well formed and sized to the image.
	function automatic void send_command();
		int w, h, fit, n, nb, lim, dx, dy, pick;
		w = dim_of(cfg_w);
		h = dim_of(cfg_h);
		fit = (cur_x < w) ? w - cur_x : 0;
		pick = $urandom_range(0, 99);
		if (pick < 36) begin
			// Encoded run, sometimes too long for the row.
			if (fit > 0 && $urandom_range(0, 9) != 0)
				n = $urandom_range(1, (fit < 255) ? fit : 255);
			else
				n = $urandom_range(1, 255);
			send_data(n[7:0]);
			send_data(8'($urandom));
		end else if (pick < 56) begin
			// Absolute run with its pad byte when the byte count is odd.
			lim = (fit < 12) ? fit : 12;
			if (lim >= 3 && $urandom_range(0, 9) != 0)
				n = $urandom_range(3, lim);
			else
				n = $urandom_range(3, ($urandom_range(0, 7) == 0) ? 255 : 20);
			nb = cfg_rle4 ? (n + 1) / 2 : n;
			send_data(ESC_LEAD);
			send_data(n[7:0]);
			for (int i = 0; i < nb; i++)
				send_data(8'($urandom));
			if (nb % 2 == 1)
				send_data(8'($urandom));
		end else if (pick < 71) begin
			send_data(ESC_LEAD);
			send_data(ESC_EOL);
		end else if (pick < 83) begin
			// Delta, mostly staying inside the image.
			if ($urandom_range(0, 7) == 0) begin
				dx = $urandom_range(0, 255);
				dy = $urandom_range(0, 255);
			end else begin
				lim = w - 1 - cur_x;
				dx = (lim > 0) ? $urandom_range(0, (lim < 255) ? lim : 255) : 0;
				lim = h - 1 - cur_y;
				dy = (lim > 0) ? $urandom_range(0, (lim < 3) ? lim : 3) : 0;
			end
			send_data(ESC_LEAD);
			send_data(ESC_DELTA);
			send_data(dx[7:0]);
			send_data(dy[7:0]);
		end else if (pick < 88) begin
			send_data(ESC_LEAD);
			send_data(ESC_EOB);
		end else if (pick < 93) begin
			send_pal(8'($urandom), RGB_W'($urandom));
		end else begin
			// Noise that breaks the byte pairing or restarts the image.
			case ($urandom_range(0, 2))
				0: send_data(8'($urandom));
				1: send_unused();
				default: send_start();
			endcase
		end
	endfunction

	// Idle pattern follows how far the run has progressed.
	function automatic int idle_stage();
		return (items_taken < 220) ? 0 : (items_taken < 440) ? 1 : 2;
	endfunction

	function automatic bit sender_idles();
		case (idle_stage())
			0: return $urandom_range(0, 99) < 27;
			1: return $urandom_range(0, 99) < 81;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_idles();
		case (idle_stage())
			0: return $urandom_range(0, 99) < 81;
			1: return $urandom_range(0, 99) < 27;
			default: return 1'b0;
		endcase
	endfunction

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_reg(logic [1:0] idx, int val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WIDTH: cfg_w = DIM_W'(val);
			REG_HEIGHT: cfg_h = DIM_W'(val);
			REG_MODE: cfg_rle4 = val[0];
			default: ;
		endcase
	endtask

	task automatic load_setting(int w, int h, int mode);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_MODE, mode);
		n_settings++;
	endtask

	// Wait until every queued transaction is taken and every result has arrived.
	task automatic drain();
		while (items_waiting.size() != 0 || req_valid || runs_due.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	// Request driver: presents queued transactions and records what they predict.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready) begin
				if (in_flight.has_res)
					runs_due.push_back(in_flight.res);
				items_taken++;
			end
			if (!req_valid || req_ready) begin
				if (items_waiting.size() != 0 && !sender_idles()) begin
					in_flight = items_waiting.pop_front();
					req <= in_flight.r;
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each accepted result with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				runs_seen++;
				if (runs_due.size() == 0) begin
					if (errors < 10)
						$display("Unexpected result at cycle %0d: x=%0d row=%0d count=%0d status=%0d",
							cycles, rsp.x_start, rsp.row, rsp.count, rsp.status);
					errors++;
				end else begin
					want_rsp = runs_due.pop_front();
					if (rsp !== want_rsp) begin
						if (errors < 10) begin
							$display("Result mismatch at cycle %0d", cycles);
							$display("  expected x=%0d row=%0d count=%0d even=%06h odd=%06h status=%0d",
								want_rsp.x_start, want_rsp.row, want_rsp.count,
								want_rsp.rgb_even, want_rsp.rgb_odd, want_rsp.status);
							$display("  actual   x=%0d row=%0d count=%0d even=%06h odd=%06h status=%0d",
								rsp.x_start, rsp.row, rsp.count, rsp.rgb_even, rsp.rgb_odd,
								rsp.status);
						end
						errors++;
					end
				end
			end
			rsp_ready <= !receiver_idles();
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles,
				runs_due.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Stimulus: reset, directed stream, then random phases under several geometries.
	initial begin
		int phase;
		int goal;
		int w, h, mode;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed stream on a 16 by 2 RLE8 image.
		load_setting(16, 2, 0);
		send_pal(8'h00, 24'h000000);
		send_pal(8'hFF, 24'hFFFFFF);
		send_start();
		send_data(8'd5);
		send_data(8'hFF);
		send_data(ESC_LEAD);
		send_data(8'd3);
		send_data(8'h00);
		send_data(8'hFF);
		send_data(8'h00);
		send_data(8'hFF);
		send_data(ESC_LEAD);
		send_data(ESC_DELTA);
		send_data(8'd4);
		send_data(8'd1);
		// Run far past the right edge is clipped and halts.
		send_data(8'd255);
		send_data(8'h00);
		// While halted data is ignored but palette writes still land.
		send_data(8'h07);
		send_pal(8'h07, RGB_W'($urandom));
		send_unused();
		send_start();
		// Line ends walk off the bottom of the image.
		repeat (3) begin
			send_data(ESC_LEAD);
			send_data(ESC_EOL);
		end
		send_start();
		send_data(ESC_LEAD);
		send_data(ESC_EOB);
		drain();

		// Random phases, each under its own geometry and mode.
		phase = 0;
		while (n_items + n_ignored < ITEM_GOAL) begin
			case (phase)
				0: begin w = 16; h = 6; mode = 1; end
				1: begin w = 1; h = 1; mode = 0; end
				2: begin w = MAX_DIM; h = MAX_DIM; mode = 1; end
				3: begin w = 8191; h = 8191; mode = 0; end
				4: begin w = 0; h = 0; mode = 1; end
				default: begin
					w = ($urandom_range(0, 3) == 0) ? $urandom_range(100, MAX_DIM)
						: $urandom_range(2, 40);
					h = $urandom_range(1, 10);
					mode = $urandom_range(0, 1);
				end
			endcase
			load_setting(w, h, mode);
			send_start();
			goal = n_items + n_ignored + PHASE_ITEMS;
			while (n_items + n_ignored < goal) begin
				send_command();
				if (stopped) begin
					repeat ($urandom_range(0, 2)) send_data(8'($urandom));
					send_start();
				end
			end
			drain();
			phase++;
		end

		$display("Drove %0d stream transactions (%0d more ignored) and checked %0d results",
			n_items, n_ignored, runs_seen);
		$display("over %0d image settings in RLE8 and RLE4 with %0d errors", n_settings, errors);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: bmp_rle_run_decoder.f
design/brd_pkg.sv
design/brd_ram.sv
design/brd_fifo.sv
design/brd_front.sv
design/brd_back.sv
design/bmp_rle_run_decoder.sv
tb/sv/tb_bmp_rle_run_decoder.sv
